// ===== sv/kss_pkg.sv =====
package kss_pkg;

  // Default sizing of the subset store
  localparam int KSS_MAX_SUBSET = 16;
  localparam int KSS_VALUE_BITS = 8;

  // Fixed field widths
  localparam int KSS_N_W    = 8;   // set_size
  localparam int KSS_K_W    = 5;   // subset_size
  localparam int KSS_POS_W  = 4;   // position
  localparam int KSS_CIDX_W = 2;   // configuration register index
  localparam int KSS_CDAT_W = 8;   // configuration write data

  // Configuration register indexes
  localparam logic [KSS_CIDX_W-1:0] KSS_REG_SET_SIZE    = 2'd0;
  localparam logic [KSS_CIDX_W-1:0] KSS_REG_SUBSET_SIZE = 2'd1;

  // Reset values of the configuration registers
  localparam logic [KSS_N_W-1:0] KSS_SET_SIZE_RST    = 8'd1;
  localparam logic [KSS_K_W-1:0] KSS_SUBSET_SIZE_RST = 5'd1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WRITE,
    ST_FINISH,
    ST_EMIT,
    ST_SPECIAL
  } kss_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;    // request transaction accepted this cycle
    logic lookup;   // capture the tail base read from the store
    logic wr_en;    // write one tail element
    logic finish;   // update sequence state, arm the emit pipeline
    logic emit;     // stream stored elements to the output
    logic special;  // send the single bad-config or empty result
  } kss_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic bad;        // subset size too large for this set or the store
    logic kzero;      // empty subset
    logic fresh;      // request starts a new sequence
    logic wr_last;    // final tail write this cycle
    logic emit_done;  // all elements handed to the output register
    logic out_free;   // output register can take a result
  } kss_sts_t;

endpackage

// ===== sv/kss_ctrl.sv =====
module kss_ctrl
  import kss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     cfg_ready_o,
  input  kss_sts_t sts_i,
  output kss_cmd_t cmd_o
);

  kss_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (sts_i.bad || sts_i.kzero) begin
            state_d = ST_SPECIAL;
          end else if (sts_i.fresh) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP:  state_d = ST_WRITE;
      ST_WRITE: begin
        if (sts_i.wr_last) state_d = ST_FINISH;
      end
      ST_FINISH:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.emit_done) state_d = ST_IDLE;
      end
      ST_SPECIAL: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cfg_ready_o = 1'b1;
        cmd_o.start = req_valid_i;
      end
      ST_LOOKUP:  cmd_o.lookup  = 1'b1;
      ST_WRITE:   cmd_o.wr_en   = 1'b1;
      ST_FINISH:  cmd_o.finish  = 1'b1;
      ST_EMIT:    cmd_o.emit    = 1'b1;
      ST_SPECIAL: cmd_o.special = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== sv/kss_dpath.sv =====
module kss_dpath
  import kss_pkg::*;
#(
  parameter int MAX_SUBSET = KSS_MAX_SUBSET,
  parameter int VALUE_BITS = KSS_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write
  input  logic                  cfg_we_i,
  input  logic [KSS_CIDX_W-1:0] cfg_index_i,
  input  logic [KSS_CDAT_W-1:0] cfg_data_i,
  // request field
  input  logic                  restart_i,
  // result
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [VALUE_BITS-1:0] element_o,
  output logic [KSS_POS_W-1:0]  position_o,
  output logic                  last_o,
  output logic                  more_o,
  output logic                  bad_config_o,
  // control
  input  kss_cmd_t              cmd_i,
  output kss_sts_t              sts_o
);

  localparam int IDX_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
  localparam int CNT_W = (IDX_W > KSS_K_W) ? IDX_W : KSS_K_W;
  localparam int CMP_W = (VALUE_BITS > KSS_N_W + 1) ? VALUE_BITS : KSS_N_W + 1;

  // configuration and sequence state
  logic [KSS_N_W-1:0]    n_q;
  logic [KSS_K_W-1:0]    k_q;
  logic [KSS_K_W-1:0]    tail_len_q;
  logic [KSS_N_W-1:0]    tail_base_q;
  logic                  active_q;
  logic                  more_q;
  logic                  bad_flag_q;
  logic [VALUE_BITS-1:0] first_q;

  // tail rewrite
  logic [KSS_K_W-1:0]    m_q;
  logic [VALUE_BITS-1:0] m2_q;
  logic [CNT_W-1:0]      wcnt_q;

  // emit pipeline
  logic [CNT_W-1:0]      rcnt_q;
  logic [CNT_W-1:0]      rd_idx_q;
  logic                  rd_v_q;

  // subset store
  logic [VALUE_BITS-1:0] mem_q [MAX_SUBSET];
  logic [VALUE_BITS-1:0] rdata_q;

  // output register
  logic                  ovalid_q;
  logic [VALUE_BITS-1:0] elem_q;
  logic [KSS_POS_W-1:0]  pos_q;
  logic                  last_q;
  logic                  omore_q;
  logic                  obad_q;

  logic [KSS_K_W-1:0]    tl_clip;
  logic [KSS_K_W:0]      m_inc;
  logic [KSS_K_W-1:0]    m_calc;
  logic                  bad, kzero, fresh, do_lookup;
  logic                  out_free, load_elem, load_spec, issue;
  logic                  rd_en;
  logic [CNT_W-1:0]      lookup_addr, wr_addr, rd_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [KSS_N_W:0]      first_final;
  logic                  more_d;

  // request classification
  assign bad   = ({3'b000, k_q} > n_q) || (int'(k_q) > MAX_SUBSET);
  assign kzero = (k_q == '0);
  assign fresh = restart_i || !active_q;
  assign do_lookup = cmd_i.start && !bad && !kzero && !fresh;

  // tail length for an advance: clip, reset when the base can still grow
  always_comb begin
    tl_clip = (tail_len_q > k_q) ? k_q : tail_len_q;
    if ({1'b0, tail_base_q} < ({1'b0, n_q} - {4'b0000, tl_clip})) begin
      tl_clip = '0;
    end
    m_inc  = {1'b0, tl_clip} + 1'b1;
    m_calc = (m_inc > {1'b0, k_q}) ? k_q : m_inc[KSS_K_W-1:0];
  end

  assign lookup_addr = CNT_W'(k_q) - CNT_W'(m_calc);
  assign wr_addr     = CNT_W'(k_q) - CNT_W'(m_q) + wcnt_q;
  assign wr_data     = m2_q + VALUE_BITS'(wcnt_q) + 1'b1;

  // output handshake and emit pipeline control
  assign out_free  = !ovalid_q || out_ready_i;
  assign load_elem = cmd_i.emit && rd_v_q && out_free;
  assign load_spec = cmd_i.special && out_free;
  assign issue     = cmd_i.emit && (rcnt_q < CNT_W'(k_q)) && (!rd_v_q || load_elem);
  assign rd_en     = issue || do_lookup;
  assign rd_addr   = issue ? rcnt_q : lookup_addr;

  // first element against its final value n-k+1
  assign first_final = {1'b0, n_q} - {4'b0000, k_q} + 1'b1;
  assign more_d      = CMP_W'(first_q) != CMP_W'(first_final);

  // subset store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr[IDX_W-1:0]];
    end
  end

  // copy of element zero for the end-of-sequence test
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (wr_addr == '0)) begin
      first_q <= wr_data;
    end
  end

  // configuration and sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= KSS_SET_SIZE_RST;
      k_q         <= KSS_SUBSET_SIZE_RST;
      tail_len_q  <= '0;
      tail_base_q <= '0;
      active_q    <= 1'b0;
    end else begin
      if (cmd_i.start && !bad && kzero) begin
        active_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        tail_len_q  <= m_q;
        tail_base_q <= KSS_N_W'(m2_q);
        active_q    <= more_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          KSS_REG_SET_SIZE: begin
            n_q      <= cfg_data_i;
            active_q <= 1'b0;
          end
          KSS_REG_SUBSET_SIZE: begin
            k_q      <= cfg_data_i[KSS_K_W-1:0];
            active_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // tail rewrite operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      bad_flag_q <= bad;
      wcnt_q     <= '0;
      if (fresh) begin
        m_q  <= k_q;
        m2_q <= '0;
      end else begin
        m_q  <= m_calc;
      end
    end
    if (cmd_i.lookup) begin
      m2_q <= rdata_q;
    end
    if (cmd_i.wr_en) begin
      wcnt_q <= wcnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      more_q <= more_d;
    end
    if (issue) begin
      rd_idx_q <= rcnt_q;
    end
  end

  // emit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= '0;
      rd_v_q <= 1'b0;
    end else if (cmd_i.finish) begin
      rcnt_q <= '0;
      rd_v_q <= 1'b0;
    end else begin
      if (issue) begin
        rcnt_q <= rcnt_q + 1'b1;
        rd_v_q <= 1'b1;
      end else if (load_elem) begin
        rd_v_q <= 1'b0;
      end
    end
  end

  // output register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_elem || load_spec) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk_i) begin
    if (load_elem) begin
      elem_q  <= rdata_q;
      pos_q   <= KSS_POS_W'(rd_idx_q);
      last_q  <= (rd_idx_q + 1'b1) == CNT_W'(k_q);
      omore_q <= more_q;
      obad_q  <= 1'b0;
    end else if (load_spec) begin
      elem_q  <= '0;
      pos_q   <= '0;
      last_q  <= 1'b1;
      omore_q <= 1'b0;
      obad_q  <= bad_flag_q;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign element_o    = elem_q;
  assign position_o   = pos_q;
  assign last_o       = last_q;
  assign more_o       = omore_q;
  assign bad_config_o = obad_q;

  assign sts_o.bad       = bad;
  assign sts_o.kzero     = kzero;
  assign sts_o.fresh     = fresh;
  assign sts_o.wr_last   = (wcnt_q + 1'b1) == CNT_W'(m_q);
  assign sts_o.emit_done = (rcnt_q == CNT_W'(k_q)) && !rd_v_q;
  assign sts_o.out_free  = out_free;

`ifndef SYNTHESIS
  // tail writes stay inside the current subset
  a_wr_in_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (wr_addr < CNT_W'(k_q)))
    else $error("tail write beyond subset size");

  // a rejected configuration leaves the sequence untouched
  a_bad_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && bad && !cfg_we_i) |=> $stable(active_q))
    else $error("bad-config request changed sequence state");

  // a bad-config result is a single, empty, final result
  a_bad_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && obad_q) |-> (last_q && !omore_q && (elem_q == '0)))
    else $error("malformed bad-config result");

  // every rewrite touches at least one element
  a_tail_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (m_q != '0))
    else $error("empty tail rewrite");
`endif

endmodule

// ===== sv/k_subset_successor.sv =====
// Lexicographic k-subset generator, one subset per request transaction.
// A restart writes all k store elements and an advance looks up the tail base and rewrites
// m elements, where m is the length of the rewritten tail (one store write per cycle, then
// one store read per cycle into the output register while the output is not stalled); the
// next request is taken only after the last element is in the output register. Reset
// (rst_ni, asynchronous, active low): n=1, k=1, no sequence active, output empty; the
// subset store is not cleared and is always written before it is read.
module k_subset_successor
  import kss_pkg::*;
#(
  parameter int MAX_SUBSET = KSS_MAX_SUBSET,
  parameter int VALUE_BITS = KSS_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [KSS_CIDX_W-1:0] cfg_index_i,
  input  logic [KSS_CDAT_W-1:0] cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] restart, rest zero
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((VALUE_BITS + KSS_POS_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
                                                // element, position, zero pad
  output logic                  m_axis_tlast,
  output logic [1:0]            m_axis_tuser    // [0] more, [1] bad_config
);

  localparam int TDATA_W = ((VALUE_BITS + KSS_POS_W + 7) / 8) * 8;

  kss_cmd_t              cmd;
  kss_sts_t              sts;
  logic                  cfg_ready;
  logic [VALUE_BITS-1:0] element;
  logic [KSS_POS_W-1:0]  position;
  logic                  more;
  logic                  bad_config;

  // Sequencer
  kss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .cfg_ready_o (cfg_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store, sequence state and output register
  kss_dpath #(
    .MAX_SUBSET (MAX_SUBSET),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .restart_i    (s_axis_tdata[0]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .element_o    (element),
    .position_o   (position),
    .last_o       (m_axis_tlast),
    .more_o       (more),
    .bad_config_o (bad_config),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  assign cfg_ready_o  = cfg_ready;

  // Result packing
  assign m_axis_tdata = TDATA_W'({position, element});
  assign m_axis_tuser = {bad_config, more};

endmodule
